// ----- rtl/core/gmdg_pkg.sv -----
// ---------------------------------------------------------------------------
// Maze generator package
// Item types, command codes and small helper functions shared by the design.
// ---------------------------------------------------------------------------
package gmdg_pkg;

   // Command codes carried by a request item.
   localparam logic [1:0] CMD_LOAD_SEED = 2'd0;
   localparam logic [1:0] CMD_GENERATE  = 2'd1;
   localparam logic [1:0] CMD_READ_VERT = 2'd2;
   localparam logic [1:0] CMD_READ_HORZ = 2'd3;

   // Directions, in the order in which neighbours are gathered.
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_DOWN  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] seed;
      logic [6:0]  grid_size;
      logic [12:0] bit_index;
   } req_type;

   typedef struct packed {
      logic       read_bit;
      logic [6:0] current_size;
      logic       index_error;
   } rsp_type;

   // One xorshift32 step with shifts 13, 17 and 5.
   function automatic logic [31:0] xorshift32(input logic [31:0] word);
      logic [31:0] t;
      t = word ^ (word << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

   // Adds one hex digit to a running residue modulo three. Sixteen is one
   // modulo three, so the digits of a word may simply be summed.
   function automatic logic [1:0] mod3_add(input logic [1:0] acc, input logic [3:0] nib);
      logic [1:0] n;
      logic [2:0] s;
      case (nib)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: n = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       n = 2'd1;
         default:                               n = 2'd2;
      endcase
      s = {1'b0, acc} + {1'b0, n};
      if (s >= 3'd3) begin
         s = s - 3'd3;
      end
      return s[1:0];
   endfunction

endpackage

// ----- rtl/core/grid_maze_dfs_generator_top.sv -----
// ---------------------------------------------------------------------------
// Grid maze generator
// Randomised depth-first maze builder with xorshift32 draws and bit readout.
// ---------------------------------------------------------------------------
// Usage: one request item carries a command. Load seed sets the generator
// word; generate builds a square maze of grid_size cells per side (zero as
// one, capped at MAX_SIZE); reads return a vertical or horizontal opening bit.
// Every request item yields exactly one response item carrying the bit read,
// the side of the last maze and an index error flag.
// The block works on one item at a time and holds req_stall high while busy.
// Load seed and reads go from idle to the finish state, which registers the
// response item. Generate first sweeps the opening stores, one entry a cycle
// over all MAX_SIZE*(MAX_SIZE+1) entries, and the visited store, then walks
// the maze under a small sequencer: each step loads the stack top, forms the
// cell index and probes four neighbours through the single visited-store read
// port, then backtracks on a dead end or draws a number and opens a passage.
// Reset clears the generator word and the maze side; reads report an index
// error until the first maze is generated, so the stores need no reset.
// A response item waits in its output register while rsp_stall is high; the
// block may accept one more item but holds its result in the finish state.
// ---------------------------------------------------------------------------
module grid_maze_dfs_generator_top #(
   parameter int MAX_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gmdg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gmdg_pkg::rsp_type rsp_data
);

   localparam int OD = MAX_SIZE * (MAX_SIZE + 1);
   localparam int CD = MAX_SIZE * MAX_SIZE;
   localparam int OW = $clog2(OD);
   localparam int CW = $clog2(CD);
   localparam int XW = $clog2(MAX_SIZE);
   localparam int SW = $clog2(MAX_SIZE + 1);
   localparam int EW = SW + 1;
   localparam int LW = $clog2(OD + 1);
   localparam int DW = $clog2(CD + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_INIT, ST_LOAD, ST_TOP, ST_PROBE,
      ST_CHECK, ST_DECIDE, ST_MOD, ST_PICK, ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [31:0]      rng_ff, rng_in;
   logic [31:0]      rand_ff, rand_in;
   logic [SW-1:0]    side_ff, side_in;
   logic [LW-1:0]    limit_ff, limit_in;
   logic             err_ff, err_in;
   logic [OW-1:0]    addr_ff, addr_in;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [XW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [CW-1:0]    cell_ff, cell_in;
   logic [1:0]       dir_ff, dir_in;
   logic [2:0]       count_ff, count_in;
   logic [1:0]       picks_ff [4];
   logic [1:0]       picks_in [4];
   logic             inb_ff, inb_in;
   logic [1:0]       acc_ff, acc_in;
   logic [2:0]       step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   gmdg_pkg::rsp_type rsp_ff, rsp_in;

   // Stores.
   logic             vert_mem [OD];
   logic             horz_mem [OD];
   logic             vis_mem  [CD];
   logic [2*XW-1:0]  stk_mem  [CD];

   logic             vert_we, horz_we, open_wd, open_re;
   logic [OW-1:0]    vert_wa, horz_wa, open_ra;
   logic             vert_q, horz_q;
   logic             vis_we, vis_wd, vis_re, vis_q;
   logic [CW-1:0]    vis_wa, vis_ra;
   logic             stk_we, stk_re;
   logic [CW-1:0]    stk_wa, stk_ra;
   logic [2*XW-1:0]  stk_wd, stk_q;

   // Scratch values for the sequencer.
   logic [SW-1:0]    gsize;
   logic [1:0]       sel;
   logic [1:0]       dsel;
   logic             inb;
   logic [CW-1:0]    nb_cell;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rng_in       = rng_ff;
      rand_in      = rand_ff;
      side_in      = side_ff;
      limit_in     = limit_ff;
      err_in       = err_ff;
      addr_in      = addr_ff;
      depth_in     = depth_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cell_in      = cell_ff;
      dir_in       = dir_ff;
      count_in     = count_ff;
      picks_in     = picks_ff;
      inb_in       = inb_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      vert_we = 1'b0;
      horz_we = 1'b0;
      vert_wa = addr_ff;
      horz_wa = addr_ff;
      open_wd = 1'b0;
      open_re = 1'b0;
      open_ra = OW'(req_data.bit_index);
      vis_we  = 1'b0;
      vis_wd  = 1'b0;
      vis_wa  = CW'(addr_ff);
      vis_re  = 1'b0;
      vis_ra  = cell_ff;
      stk_we  = 1'b0;
      stk_wa  = CW'(depth_ff);
      stk_wd  = '0;
      stk_re  = 1'b0;
      stk_ra  = CW'(depth_ff - DW'(1));

      gsize   = '0;
      sel     = 2'd0;
      dsel    = 2'd0;
      inb     = 1'b0;
      nb_cell = cell_ff;

      // Neighbour in the probed direction: bounds and cell index.
      case (dir_ff)
         gmdg_pkg::DIR_RIGHT: begin
            inb     = (EW'(cx_ff) + EW'(1)) < EW'(side_ff);
            nb_cell = cell_ff + CW'(1);
         end
         gmdg_pkg::DIR_LEFT: begin
            inb     = (cx_ff != '0);
            nb_cell = cell_ff - CW'(1);
         end
         gmdg_pkg::DIR_DOWN: begin
            inb     = (EW'(cy_ff) + EW'(1)) < EW'(side_ff);
            nb_cell = cell_ff + CW'(side_ff);
         end
         default: begin
            inb     = (cy_ff != '0);
            nb_cell = cell_ff - CW'(side_ff);
         end
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data.command;
               err_in = 1'b0;
               case (req_data.command)
                  gmdg_pkg::CMD_LOAD_SEED: begin
                     rng_in   = req_data.seed;
                     state_in = ST_FINISH;
                  end
                  gmdg_pkg::CMD_GENERATE: begin
                     if (req_data.grid_size == 7'd0) begin
                        gsize = SW'(1);
                     end else if (32'(req_data.grid_size) > MAX_SIZE) begin
                        gsize = SW'(MAX_SIZE);
                     end else begin
                        gsize = SW'(req_data.grid_size);
                     end
                     side_in  = gsize;
                     limit_in = LW'(LW'(gsize) * (LW'(gsize) + LW'(1)));
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     err_in   = 32'(req_data.bit_index) >= 32'(limit_ff);
                     open_re  = 1'b1;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         // Sweep both opening stores and the visited map.
         ST_CLEAR: begin
            vert_we = 1'b1;
            horz_we = 1'b1;
            vis_we  = (32'(addr_ff) < CD);
            if (32'(addr_ff) == OD - 1) begin
               state_in = ST_INIT;
            end else begin
               addr_in = addr_ff + OW'(1);
            end
         end

         // Start the walk at cell 0.
         ST_INIT: begin
            vis_we   = 1'b1;
            vis_wd   = 1'b1;
            vis_wa   = '0;
            stk_we   = 1'b1;
            stk_wa   = '0;
            stk_wd   = '0;
            depth_in = DW'(1);
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            stk_re   = 1'b1;
            state_in = ST_TOP;
         end

         // Top of stack has arrived: form the cell index.
         ST_TOP: begin
            cx_in    = stk_q[XW-1:0];
            cy_in    = stk_q[2*XW-1:XW];
            cell_in  = CW'(CW'(stk_q[2*XW-1:XW]) * CW'(side_ff) + CW'(stk_q[XW-1:0]));
            dir_in   = gmdg_pkg::DIR_RIGHT;
            count_in = '0;
            state_in = ST_PROBE;
         end

         ST_PROBE: begin
            inb_in   = inb;
            vis_re   = inb;
            vis_ra   = nb_cell;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (inb_ff && !vis_q) begin
               picks_in[count_ff[1:0]] = dir_ff;
               count_in = count_ff + 3'd1;
            end
            if (dir_ff == gmdg_pkg::DIR_UP) begin
               state_in = ST_DECIDE;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = ST_PROBE;
            end
         end

         // Backtrack on a dead end, otherwise draw a number.
         ST_DECIDE: begin
            if (count_ff == 3'd0) begin
               depth_in = depth_ff - DW'(1);
               state_in = (depth_ff == DW'(1)) ? ST_FINISH : ST_LOAD;
            end else begin
               rng_in   = gmdg_pkg::xorshift32(rng_ff);
               rand_in  = gmdg_pkg::xorshift32(rng_ff);
               acc_in   = 2'd0;
               step_in  = 3'd0;
               state_in = (count_ff == 3'd3) ? ST_MOD : ST_PICK;
            end
         end

         // Residue modulo three, one hex digit a cycle.
         ST_MOD: begin
            acc_in  = gmdg_pkg::mod3_add(acc_ff, rand_ff[3:0]);
            rand_in = rand_ff >> 4;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = ST_PICK;
            end
         end

         // Open the chosen passage and push the new cell.
         ST_PICK: begin
            case (count_ff)
               3'd3:    sel = acc_ff;
               3'd4:    sel = rand_ff[1:0];
               3'd2:    sel = {1'b0, rand_ff[0]};
               default: sel = 2'd0;
            endcase
            dsel    = picks_ff[sel];
            vis_we  = 1'b1;
            vis_wd  = 1'b1;
            open_wd = 1'b1;
            stk_we  = (32'(depth_ff) < CD);
            if (32'(depth_ff) < CD) begin
               depth_in = depth_ff + DW'(1);
            end
            case (dsel)
               gmdg_pkg::DIR_RIGHT: begin
                  vis_wa  = cell_ff + CW'(1);
                  stk_wd  = {cy_ff, cx_ff + XW'(1)};
                  vert_we = 1'b1;
                  vert_wa = OW'(cell_ff) + OW'(cy_ff) + OW'(1);
               end
               gmdg_pkg::DIR_LEFT: begin
                  vis_wa  = cell_ff - CW'(1);
                  stk_wd  = {cy_ff, cx_ff - XW'(1)};
                  vert_we = 1'b1;
                  vert_wa = OW'(cell_ff) + OW'(cy_ff);
               end
               gmdg_pkg::DIR_DOWN: begin
                  vis_wa  = cell_ff + CW'(side_ff);
                  stk_wd  = {cy_ff + XW'(1), cx_ff};
                  horz_we = 1'b1;
                  horz_wa = OW'(cell_ff) + OW'(side_ff);
               end
               default: begin
                  vis_wa  = cell_ff - CW'(side_ff);
                  stk_wd  = {cy_ff - XW'(1), cx_ff};
                  horz_we = 1'b1;
                  horz_wa = OW'(cell_ff);
               end
            endcase
            state_in = ST_LOAD;
         end

         // Hand the response item over once the output register is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.current_size  = 7'(side_ff);
               rsp_in.index_error   = 1'b0;
               rsp_in.read_bit      = 1'b0;
               if (cmd_ff == gmdg_pkg::CMD_READ_VERT || cmd_ff == gmdg_pkg::CMD_READ_HORZ) begin
                  rsp_in.index_error = err_ff;
                  rsp_in.read_bit    = !err_ff &&
                     ((cmd_ff == gmdg_pkg::CMD_READ_VERT) ? vert_q : horz_q);
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rng_ff       <= '0;
         side_ff      <= '0;
         limit_ff     <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         side_ff      <= side_in;
         limit_ff     <= limit_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      rand_ff  <= rand_in;
      err_ff   <= err_in;
      addr_ff  <= addr_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cell_ff  <= cell_in;
      dir_ff   <= dir_in;
      picks_ff <= picks_in;
      inb_ff   <= inb_in;
      acc_ff   <= acc_in;
      step_ff  <= step_in;
      rsp_ff   <= rsp_in;
   end

   // Opening stores: one write port each, shared read address, registered read data.
   always_ff @(posedge clock) begin
      if (vert_we) begin
         vert_mem[vert_wa] <= open_wd;
      end
      if (horz_we) begin
         horz_mem[horz_wa] <= open_wd;
      end
      if (open_re) begin
         vert_q <= vert_mem[open_ra];
         horz_q <= horz_mem[open_ra];
      end
   end

   // Visited map.
   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_wa] <= vis_wd;
      end
      if (vis_re) begin
         vis_q <= vis_mem[vis_ra];
      end
   end

   // Cell stack of packed coordinates.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stk_q <= stk_mem[stk_ra];
      end
   end

   // The stack never grows beyond the number of cells.
   assert property (@(posedge clock) disable iff (reset) 32'(depth_ff) <= CD)
      else $error("cell stack depth beyond its store");

   // At most four neighbours can be gathered.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 3'd4)
      else $error("neighbour count out of range");

   // The walk only probes from cells inside the maze.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> (EW'(cx_ff) < EW'(side_ff) && EW'(cy_ff) < EW'(side_ff)))
      else $error("walk position outside the maze");

   // An index error never comes with a set bit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.index_error |-> !rsp_ff.read_bit)
      else $error("read bit set on an index error");

   // A passage is only picked once a neighbour has been gathered.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK |-> count_ff != 3'd0)
      else $error("passage picked with no neighbour");

endmodule
